// File: rtl/feel_pkg.sv
// shared constants, command/status structs and limit table for the parameter log unit
package feel_pkg;

    localparam int PARAM_COUNT = 7;
    localparam int IDX_W       = 3;
    localparam int WO_W        = 13;

    localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

    localparam logic [2:0] KIND_INIT_BEGIN = 3'd0;
    localparam logic [2:0] KIND_INIT_WORD  = 3'd1;
    localparam logic [2:0] KIND_INIT_END   = 3'd2;
    localparam logic [2:0] KIND_UPDATE     = 3'd3;
    localparam logic [2:0] KIND_FLUSH      = 3'd4;
    localparam logic [2:0] KIND_READ       = 3'd5;

    localparam logic [2:0] ACT_ACK     = 3'd0;
    localparam logic [2:0] ACT_PROGRAM = 3'd1;
    localparam logic [2:0] ACT_ERASE   = 3'd2;
    localparam logic [2:0] ACT_READ    = 3'd3;
    localparam logic [2:0] ACT_REFUSED = 3'd4;

    localparam logic [1:0] CFG_SECTOR_BASE  = 2'd0;
    localparam logic [1:0] CFG_SECTOR_NUM   = 2'd1;
    localparam logic [1:0] CFG_PAGE_WORDS   = 2'd2;
    localparam logic [1:0] CFG_ERASE_OFFSET = 2'd3;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_SCAN  = 2'd1,
        PH_BLANK = 2'd2
    } t_phase;

    typedef struct packed {
        logic latch;
        logic exec;
        logic read_emit;
        logic pre_scan;
        logic idx_clr;
        logic idx_inc;
        logic prog;
        logic use_def;
        logic erase;
        logic done;
    } t_cmd;

    typedef struct packed {
        logic [2:0] kind;
        logic       ph_scan;
        logic       ph_blank;
        logic       top_found;
        logic       erase_pending;
        logic       cur_synced;
        logic       idx_last;
        logic       wo_ge_erase;
        logic       can_emit;
        logic       out_free;
    } t_stat;

    function automatic logic signed [15:0] lim_min(input logic [IDX_W-1:0] i);
        lim_min = 16'sd0;
    endfunction

    function automatic logic signed [15:0] lim_max(input logic [IDX_W-1:0] i);
        unique case (i)
            3'd5, 3'd6: lim_max = 16'sd2500;
            3'd7:       lim_max = 16'sd0;
            default:    lim_max = 16'sd1000;
        endcase
    endfunction

    function automatic logic signed [15:0] lim_def(input logic [IDX_W-1:0] i);
        unique case (i)
            3'd0:    lim_def = 16'sd800;
            3'd1:    lim_def = 16'sd600;
            3'd2:    lim_def = 16'sd200;
            3'd3:    lim_def = 16'sd700;
            3'd4:    lim_def = 16'sd150;
            3'd5:    lim_def = 16'sd350;
            3'd6:    lim_def = 16'sd700;
            default: lim_def = 16'sd0;
        endcase
    endfunction

endpackage

// File: rtl/feel_ctrl.sv
// sequencer that walks each item through its steps and issues datapath commands
module feel_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  feel_pkg::t_stat i_stat,
    output feel_pkg::t_cmd  o_cmd
);
    import feel_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_EXEC = 7'b0000010,
        S_L1   = 7'b0000100,
        S_CHK  = 7'b0001000,
        S_L2   = 7'b0010000,
        S_DONE = 7'b0100000,
        S_PRE  = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_EXEC;
                end
            end
            S_EXEC: begin
                priority if (i_stat.kind == KIND_INIT_END) begin
                    priority if (i_stat.ph_scan) begin
                        o_cmd.pre_scan = 1'b1;
                        o_cmd.idx_clr  = 1'b1;
                        n_state        = S_L1;
                    end else if (i_stat.ph_blank) begin
                        n_state = S_PRE;
                    end else begin
                        n_state = S_DONE;
                    end
                end else if (i_stat.kind == KIND_FLUSH) begin
                    o_cmd.idx_clr = 1'b1;
                    n_state       = S_L1;
                end else if (i_stat.kind == KIND_READ) begin
                    if (i_stat.can_emit) begin
                        o_cmd.read_emit = 1'b1;
                        n_state         = S_DONE;
                    end
                end else begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_DONE;
                end
            end
            S_PRE: begin
                // blank-check init end: erase first when flagged
                if (!i_stat.erase_pending) begin
                    o_cmd.idx_clr = 1'b1;
                    n_state       = S_L2;
                end else if (i_stat.can_emit) begin
                    o_cmd.erase   = 1'b1;
                    o_cmd.idx_clr = 1'b1;
                    n_state       = S_L2;
                end
            end
            S_L1: begin
                if (i_stat.cur_synced || i_stat.can_emit) begin
                    o_cmd.prog    = !i_stat.cur_synced;
                    o_cmd.use_def = (i_stat.kind == KIND_INIT_END);
                    if (i_stat.idx_last) begin
                        n_state = (i_stat.kind == KIND_INIT_END) ? S_CHK : S_DONE;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                    end
                end
            end
            S_CHK: begin
                if (!i_stat.wo_ge_erase) begin
                    n_state = S_DONE;
                end else if (i_stat.can_emit) begin
                    o_cmd.erase   = 1'b1;
                    o_cmd.idx_clr = 1'b1;
                    n_state       = S_L2;
                end
            end
            S_L2: begin
                if (i_stat.can_emit) begin
                    o_cmd.prog    = 1'b1;
                    o_cmd.use_def = i_stat.ph_blank;
                    if (i_stat.idx_last) begin
                        n_state = S_DONE;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                    end
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.done = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: rtl/feel_dp.sv
// datapath: config registers, mirror, sync bits, log pointer, pending and output result
module feel_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data,
    input  logic [2:0]          i_kind,
    input  logic [31:0]         i_flash_word,
    input  logic [11:0]         i_word_offset,
    input  logic [2:0]          i_param_index,
    input  logic signed [15:0]  i_param_value,
    input  feel_pkg::t_cmd      i_cmd,
    output feel_pkg::t_stat     o_stat,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [2:0]          o_action,
    output logic [31:0]         o_flash_address,
    output logic [31:0]         o_flash_word_out,
    output logic [2:0]          o_sector,
    output logic signed [15:0]  o_read_value,
    output logic                o_last
);
    import feel_pkg::*;

    // configuration
    logic [31:0]     r_base;
    logic [2:0]      r_secnum;
    logic [WO_W-1:0] r_page_words;
    logic [WO_W-1:0] r_erase_off;

    // latched item
    logic [2:0]         r_kind;
    logic [31:0]        r_fw;
    logic [11:0]        r_off;
    logic signed [15:0] r_pval;
    logic [IDX_W-1:0]   r_idx, n_idx;

    // store state
    logic signed [15:0]     r_mirror [PARAM_COUNT];
    logic signed [15:0]     n_mirror [PARAM_COUNT];
    logic [PARAM_COUNT-1:0] r_sync, n_sync;
    logic [WO_W-1:0]        r_wo, n_wo;
    logic                   r_ep, n_ep;
    t_phase                 r_phase, n_phase;
    logic                   r_top, n_top;

    // pending result and output register
    logic               r_pv, n_pv;
    logic [2:0]         r_pact, n_pact;
    logic [31:0]        r_paddr, n_paddr;
    logic [31:0]        r_pword, n_pword;
    logic [2:0]         r_psec, n_psec;
    logic signed [15:0] r_prv, n_prv;

    logic               r_ov, n_ov;
    logic [2:0]         r_oact, n_oact;
    logic [31:0]        r_oaddr, n_oaddr;
    logic [31:0]        r_oword, n_oword;
    logic [2:0]         r_osec, n_osec;
    logic signed [15:0] r_orv, n_orv;
    logic               r_olast, n_olast;

    logic               idx_ok;
    logic signed [15:0] cur_val;
    logic               out_free;
    logic               emit;
    logic [2:0]         e_act;
    logic [31:0]        e_addr;
    logic [31:0]        e_word;
    logic [2:0]         e_sec;
    logic signed [15:0] e_rv;
    logic signed [15:0] pg_val;
    logic [15:0]        w_idx;
    logic [IDX_W-1:0]   w_idx3;
    logic signed [15:0] w_val;
    logic               w_in_page;

    assign idx_ok   = (32'(r_idx) < PARAM_COUNT);
    assign cur_val  = idx_ok ? r_mirror[r_idx] : 16'sd0;
    assign out_free = !r_ov || i_out_ready;

    assign w_idx     = r_fw[15:0];
    assign w_idx3    = w_idx[IDX_W-1:0];
    assign w_val     = r_fw[31:16];
    assign w_in_page = ({1'b0, r_off} < r_page_words);

    always_comb begin
        o_stat.kind          = r_kind;
        o_stat.ph_scan       = (r_phase == PH_SCAN);
        o_stat.ph_blank      = (r_phase == PH_BLANK);
        o_stat.top_found     = r_top;
        o_stat.erase_pending = r_ep;
        o_stat.cur_synced    = idx_ok ? r_sync[r_idx] : 1'b1;
        o_stat.idx_last      = (32'(r_idx) == PARAM_COUNT - 1);
        o_stat.wo_ge_erase   = (r_wo >= r_erase_off);
        o_stat.can_emit      = !r_pv || out_free;
        o_stat.out_free      = out_free;
    end

    always_comb begin
        n_idx    = r_idx;
        n_mirror = r_mirror;
        n_sync   = r_sync;
        n_wo     = r_wo;
        n_ep     = r_ep;
        n_phase  = r_phase;
        n_top    = r_top;
        emit     = 1'b0;
        e_act    = ACT_ACK;
        e_addr   = '0;
        e_word   = '0;
        e_sec    = '0;
        e_rv     = '0;
        pg_val   = i_cmd.use_def ? lim_def(r_idx) : cur_val;

        if (i_cmd.idx_clr) begin
            n_idx = '0;
        end
        if (i_cmd.idx_inc) begin
            n_idx = r_idx + 1'b1;
        end

        if (i_cmd.exec) begin
            unique case (r_kind)
                KIND_INIT_BEGIN: begin
                    n_wo   = '0;
                    n_sync = '0;
                    n_top  = 1'b0;
                    if (r_fw[15:0] == 16'd0) begin
                        n_phase = PH_SCAN;
                        n_ep    = 1'b0;
                    end else begin
                        n_phase = PH_BLANK;
                        n_ep    = (r_fw != ALL_ONES);
                    end
                end
                KIND_INIT_WORD: begin
                    if (r_phase == PH_SCAN && w_in_page &&
                        (r_top || r_fw != ALL_ONES || r_off == 12'd0)) begin
                        if (!r_top) begin
                            n_top = 1'b1;
                            n_wo  = {1'b0, r_off} + 1'b1;
                        end
                        if (32'(w_idx) < PARAM_COUNT && !r_sync[w_idx3] &&
                            w_val >= lim_min(w_idx3) && w_val <= lim_max(w_idx3)) begin
                            n_mirror[w_idx3] = w_val;
                            n_sync[w_idx3]   = 1'b1;
                        end
                    end else if (r_phase == PH_BLANK && r_fw != ALL_ONES && w_in_page) begin
                        n_ep = 1'b1;
                    end
                end
                KIND_UPDATE: begin
                    if (idx_ok && cur_val != r_pval) begin
                        n_mirror[r_idx] = r_pval;
                        n_sync[r_idx]   = 1'b0;
                    end
                end
                default: ;
            endcase
        end

        if (i_cmd.pre_scan && !r_top) begin
            n_wo = WO_W'(1);
        end

        if (i_cmd.read_emit) begin
            emit  = 1'b1;
            e_act = ACT_READ;
            e_rv  = cur_val;
        end

        if (i_cmd.erase) begin
            emit   = 1'b1;
            e_act  = ACT_ERASE;
            e_sec  = r_secnum;
            n_wo   = '0;
            n_sync = '0;
            n_ep   = 1'b0;
        end

        if (i_cmd.prog) begin
            emit = 1'b1;
            if (i_cmd.use_def) begin
                n_mirror[r_idx] = pg_val;
            end
            if (r_wo >= r_page_words) begin
                n_ep  = 1'b1;
                e_act = ACT_REFUSED;
            end else begin
                e_act         = ACT_PROGRAM;
                e_addr        = r_base + {17'd0, r_wo, 2'b00};
                e_word        = {pg_val, 13'd0, r_idx};
                n_sync[r_idx] = 1'b1;
                n_wo          = r_wo + 1'b1;
            end
        end

        if (i_cmd.done && r_kind == KIND_INIT_END) begin
            n_phase = PH_IDLE;
            n_top   = 1'b0;
        end
    end

    // pending slot holds the newest result until it is known whether another follows
    always_comb begin
        n_pv    = r_pv;
        n_pact  = r_pact;
        n_paddr = r_paddr;
        n_pword = r_pword;
        n_psec  = r_psec;
        n_prv   = r_prv;
        n_ov    = r_ov && !i_out_ready;
        n_oact  = r_oact;
        n_oaddr = r_oaddr;
        n_oword = r_oword;
        n_osec  = r_osec;
        n_orv   = r_orv;
        n_olast = r_olast;
        if (emit) begin
            if (r_pv) begin
                n_ov    = 1'b1;
                n_oact  = r_pact;
                n_oaddr = r_paddr;
                n_oword = r_pword;
                n_osec  = r_psec;
                n_orv   = r_prv;
                n_olast = 1'b0;
            end
            n_pv    = 1'b1;
            n_pact  = e_act;
            n_paddr = e_addr;
            n_pword = e_word;
            n_psec  = e_sec;
            n_prv   = e_rv;
        end else if (i_cmd.done) begin
            n_ov    = 1'b1;
            n_olast = 1'b1;
            n_pv    = 1'b0;
            if (r_pv) begin
                n_oact  = r_pact;
                n_oaddr = r_paddr;
                n_oword = r_pword;
                n_osec  = r_psec;
                n_orv   = r_prv;
            end else begin
                n_oact  = ACT_ACK;
                n_oaddr = '0;
                n_oword = '0;
                n_osec  = '0;
                n_orv   = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base       <= 32'd134266880;
            r_secnum     <= 3'd3;
            r_page_words <= WO_W'(4096);
            r_erase_off  <= WO_W'(3072);
            r_mirror     <= '{default: 16'sd0};
            r_sync       <= '0;
            r_wo         <= '0;
            r_ep         <= 1'b0;
            r_phase      <= PH_IDLE;
            r_top        <= 1'b0;
            r_pv         <= 1'b0;
            r_ov         <= 1'b0;
            r_kind       <= KIND_INIT_BEGIN;
            r_idx        <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_SECTOR_BASE:  r_base       <= i_cfg_data;
                    CFG_SECTOR_NUM:   r_secnum     <= i_cfg_data[2:0];
                    CFG_PAGE_WORDS:   r_page_words <= i_cfg_data[WO_W-1:0];
                    CFG_ERASE_OFFSET: r_erase_off  <= i_cfg_data[WO_W-1:0];
                    default: ;
                endcase
            end
            r_mirror <= n_mirror;
            r_sync   <= n_sync;
            r_wo     <= n_wo;
            r_ep     <= n_ep;
            r_phase  <= n_phase;
            r_top    <= n_top;
            r_pv     <= n_pv;
            r_ov     <= n_ov;
            if (i_cmd.latch) begin
                r_kind <= i_kind;
                r_idx  <= i_param_index;
            end else begin
                r_idx  <= n_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_fw   <= i_flash_word;
            r_off  <= i_word_offset;
            r_pval <= i_param_value;
        end
        r_pact  <= n_pact;
        r_paddr <= n_paddr;
        r_pword <= n_pword;
        r_psec  <= n_psec;
        r_prv   <= n_prv;
        r_oact  <= n_oact;
        r_oaddr <= n_oaddr;
        r_oword <= n_oword;
        r_osec  <= n_osec;
        r_orv   <= n_orv;
        r_olast <= n_olast;
    end

    assign o_out_valid      = r_ov;
    assign o_action         = r_oact;
    assign o_flash_address  = r_oaddr;
    assign o_flash_word_out = r_oword;
    assign o_sector         = r_osec;
    assign o_read_value     = r_orv;
    assign o_last           = r_olast;

endmodule

// File: rtl/flash_eeprom_emulation_log_unit.sv
// top level of the flash-backed parameter log unit
// Keeps a mirror of seven signed 16-bit parameters with one sync bit each and a log
// write pointer into one flash sector; log words are value in the upper half and
// index in the lower half. Items are taken one at a time: in_ready is high only when
// the sequencer is idle. Flash operations are reported as result items (program,
// erase, page-full refusal, read data, ack), the final one of each item flagged by
// last. Init begin, init word, update, read, the unused kinds and an init end outside
// an init sequence need no walk over the parameters. A flush steps the sequencer once
// per parameter. An init end walks them with an extra step, the erase check after
// a scan or the erase step in blank-check mode, and one that erases and rewrites
// after a scan walks them twice. Each emitted result passes through a one-deep
// pending slot and a registered output; a stalled consumer holds up the sequencer.
// No clearing pass after reset. Configuration writes take effect at once.
module flash_eeprom_emulation_log_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration write port
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    // input item channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [2:0]         i_kind,
    input  logic [31:0]        i_flash_word,
    input  logic [11:0]        i_word_offset,
    input  logic [2:0]         i_param_index,
    input  logic signed [15:0] i_param_value,
    // result item channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [2:0]         o_action,
    output logic [31:0]        o_flash_address,
    output logic [31:0]        o_flash_word_out,
    output logic [2:0]         o_sector,
    output logic signed [15:0] o_read_value,
    output logic               o_last
);
    import feel_pkg::*;

    // command and status between sequencer and datapath
    t_cmd  cmd;
    t_stat stat;

    feel_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    feel_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_kind           (i_kind),
        .i_flash_word     (i_flash_word),
        .i_word_offset    (i_word_offset),
        .i_param_index    (i_param_index),
        .i_param_value    (i_param_value),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_action         (o_action),
        .o_flash_address  (o_flash_address),
        .o_flash_word_out (o_flash_word_out),
        .o_sector         (o_sector),
        .o_read_value     (o_read_value),
        .o_last           (o_last)
    );

endmodule

// File: bench/flash_eeprom_emulation_log_unit_test.sv
// self-checking bench for the flash-backed parameter log unit with a scoreboard class
`timescale 1ns / 1ps

module flash_eeprom_emulation_log_unit_test;
    import feel_pkg::*;

    localparam int STALL_LIMIT = 3000;  // cycles with no item moving on either channel
    localparam int SETTLE      = 40;    // settle time for the sequencer and output slots after the last result

    typedef struct {
        logic [2:0]         action;
        logic [31:0]        addr;
        logic [31:0]        word;
        logic [2:0]         sector;
        logic signed [15:0] rv;
        logic               last;
    } t_flash_op;

    // scoreboard: shadow copy of the log unit plus the queue of flash ops still due
    class log_scoreboard;
        logic [31:0]        base_addr;
        logic [2:0]         sector_num;
        logic [12:0]        page_len;
        logic [12:0]        erase_level;
        logic signed [15:0] mirror [PARAM_COUNT];
        logic [PARAM_COUNT-1:0] synced;
        logic [12:0]        wr_ptr;
        logic               erase_due;
        t_phase             phase;
        logic               found_top;
        t_flash_op          due_ops [$];
        t_flash_op          batch [$];
        int                 mismatches;

        function new();
            base_addr   = 32'd134266880;
            sector_num  = 3'd3;
            page_len    = 13'd4096;
            erase_level = 13'd3072;
            foreach (mirror[i]) mirror[i] = '0;
            synced      = '0;
            wr_ptr      = '0;
            erase_due   = 1'b0;
            phase       = PH_IDLE;
            found_top   = 1'b0;
            mismatches  = 0;
        endfunction

        function logic signed [15:0] max_of(int i);
            return (i >= 5) ? 16'sd2500 : 16'sd1000;
        endfunction

        function logic signed [15:0] default_of(int i);
            logic signed [15:0] defs [PARAM_COUNT];
            defs = '{16'sd800, 16'sd600, 16'sd200, 16'sd700, 16'sd150, 16'sd350, 16'sd700};
            return defs[i];
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] data);
            case (idx)
                CFG_SECTOR_BASE:  base_addr   = data;
                CFG_SECTOR_NUM:   sector_num  = data[2:0];
                CFG_PAGE_WORDS:   page_len    = data[12:0];
                CFG_ERASE_OFFSET: erase_level = data[12:0];
            endcase
        endfunction

        function void push_op(logic [2:0] act, logic [31:0] a, logic [31:0] w,
                              logic [2:0] s, logic signed [15:0] v);
            t_flash_op op;
            op = '{act, a, w, s, v, 1'b0};
            batch.push_back(op);
        endfunction

        function void erase_sector();
            push_op(ACT_ERASE, '0, '0, sector_num, '0);
            wr_ptr    = '0;
            synced    = '0;
            erase_due = 1'b0;
        endfunction

        function void program_param(int i);
            if (wr_ptr >= page_len) begin
                // page full: refuse and ask for an erase later
                erase_due = 1'b1;
                push_op(ACT_REFUSED, '0, '0, '0, '0);
                return;
            end
            push_op(ACT_PROGRAM, base_addr + 32'(wr_ptr) * 4, {mirror[i], 16'(i)}, '0, '0);
            synced[i] = 1'b1;
            wr_ptr    = wr_ptr + 13'd1;
        endfunction

        function void scan_log_word(logic [31:0] w, logic [11:0] off);
            logic [15:0]        idx;
            logic signed [15:0] val;
            idx = w[15:0];
            val = w[31:16];
            if (13'(off) >= page_len) return;
            if (!found_top) begin
                if (w == ALL_ONES && off != 0) return;
                found_top = 1'b1;
                wr_ptr    = 13'(off) + 13'd1;
            end
            if (idx < PARAM_COUNT && !synced[idx] && val >= 0 && val <= max_of(idx)) begin
                mirror[idx] = val;
                synced[idx] = 1'b1;
            end
        endfunction

        // note one accepted input item and queue the flash ops it causes
        function void note_input(logic [2:0] kind, logic [31:0] fw, logic [11:0] off,
                                 logic [2:0] pidx, logic signed [15:0] pval);
            batch.delete();
            case (kind)
                KIND_INIT_BEGIN: begin
                    wr_ptr = '0; synced = '0; erase_due = 1'b0; found_top = 1'b0;
                    if (fw[15:0] == 16'd0) phase = PH_SCAN;
                    else begin
                        phase = PH_BLANK;
                        if (fw != ALL_ONES) erase_due = 1'b1;
                    end
                end
                KIND_INIT_WORD: begin
                    if (phase == PH_SCAN) scan_log_word(fw, off);
                    else if (phase == PH_BLANK && fw != ALL_ONES && 13'(off) < page_len)
                        erase_due = 1'b1;
                end
                KIND_INIT_END: begin
                    if (phase == PH_SCAN) begin
                        if (!found_top) wr_ptr = 13'd1;
                        for (int i = 0; i < PARAM_COUNT; i++)
                            if (!synced[i]) begin
                                mirror[i] = default_of(i);
                                program_param(i);
                            end
                        // log too full: erase and rewrite the whole mirror
                        if (wr_ptr >= erase_level) begin
                            erase_sector();
                            for (int i = 0; i < PARAM_COUNT; i++) program_param(i);
                        end
                    end else if (phase == PH_BLANK) begin
                        if (erase_due) erase_sector();
                        for (int i = 0; i < PARAM_COUNT; i++) begin
                            mirror[i] = default_of(i);
                            program_param(i);
                        end
                    end
                    phase     = PH_IDLE;
                    found_top = 1'b0;
                end
                KIND_UPDATE: begin
                    if (pidx < PARAM_COUNT && mirror[pidx] != pval) begin
                        mirror[pidx] = pval;
                        synced[pidx] = 1'b0;
                    end
                end
                KIND_FLUSH: begin
                    for (int i = 0; i < PARAM_COUNT; i++)
                        if (!synced[i]) program_param(i);
                end
                KIND_READ: begin
                    push_op(ACT_READ, '0, '0, '0, (pidx < PARAM_COUNT) ? mirror[pidx] : '0);
                end
                default: ;
            endcase
            if (batch.size() == 0) push_op(ACT_ACK, '0, '0, '0, '0);
            batch[batch.size()-1].last = 1'b1;
            foreach (batch[i]) due_ops.push_back(batch[i]);
        endfunction

        // compare one result item against the oldest flash op due
        function void check_result(t_flash_op got);
            t_flash_op exp;
            if (due_ops.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: action %0d addr %h word %h",
                             got.action, got.addr, got.word);
                return;
            end
            exp = due_ops.pop_front();
            if (got.action !== exp.action || got.addr !== exp.addr || got.word !== exp.word ||
                got.sector !== exp.sector || got.rv !== exp.rv || got.last !== exp.last) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch: exp act %0d addr %h word %h sec %0d rv %0d last %0d",
                             exp.action, exp.addr, exp.word, exp.sector, exp.rv, exp.last);
                    $display("          got act %0d addr %h word %h sec %0d rv %0d last %0d",
                             got.action, got.addr, got.word, got.sector, got.rv, got.last);
                end
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [1:0]         i_cfg_index = '0;
    logic [31:0]        i_cfg_data = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic [2:0]         i_kind = '0;
    logic [31:0]        i_flash_word = '0;
    logic [11:0]        i_word_offset = '0;
    logic [2:0]         i_param_index = '0;
    logic signed [15:0] i_param_value = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [2:0]         o_action;
    logic [31:0]        o_flash_address;
    logic [31:0]        o_flash_word_out;
    logic [2:0]         o_sector;
    logic signed [15:0] o_read_value;
    logic               o_last;

    flash_eeprom_emulation_log_unit DUT (.*);

    log_scoreboard sb = new();
    bit  calm;          // no idling on either side while set
    bit  hold_request;  // asks the receiver for one long hold-off
    int  quiet_cycles;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // both channels are watched at the rising edge, before any input change
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready)
                sb.note_input(i_kind, i_flash_word, i_word_offset, i_param_index,
                              i_param_value);
            if (o_out_valid && i_out_ready)
                sb.check_result('{o_action, o_flash_address, o_flash_word_out, o_sector,
                                  o_read_value, o_last});
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // receiver: random back-pressure, one long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready = 1'b0;
            end else
                i_out_ready = calm || ($urandom_range(0, 99) >= 32);
        end
    end

    // offer one item and hold it until taken; called at a falling edge
    task automatic send_item(logic [2:0] kind, logic [31:0] fw, logic [11:0] off,
                             logic [2:0] pidx, logic signed [15:0] pval);
        while (!calm && $urandom_range(0, 99) < 32) @(negedge i_clk);
        i_in_valid    = 1'b1;
        i_kind        = kind;
        i_flash_word  = fw;
        i_word_offset = off;
        i_param_index = pidx;
        i_param_value = pval;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    // let every due op drain, then the sequencer settle, before touching registers
    task automatic drain();
        while (sb.due_ops.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        sb.set_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic setup(logic [31:0] base, logic [2:0] sec, logic [12:0] pw, logic [12:0] eo);
        drain();
        write_reg(CFG_SECTOR_BASE, base);
        write_reg(CFG_SECTOR_NUM, 32'(sec));
        write_reg(CFG_PAGE_WORDS, 32'(pw));
        write_reg(CFG_ERASE_OFFSET, 32'(eo));
    endtask

    // a log word: mostly values up to 2600 for indexes 0 to 8, some erased or junk
    function automatic logic [31:0] log_word();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) return ALL_ONES;
        if (r < 85) return {16'($urandom_range(0, 2600)), 16'($urandom_range(0, 8))};
        return $urandom;
    endfunction

    // one init sequence; broken ones drop the begin or the end
    task automatic init_sequence(ref int sent);
        int          words;
        int          broken;
        logic [11:0] off;
        broken = $urandom_range(0, 9);
        if (broken != 0) begin
            if ($urandom_range(0, 9) < 7)
                send_item(KIND_INIT_BEGIN, {16'($urandom), 16'd0}, '0, '0, '0);
            else
                send_item(KIND_INIT_BEGIN,
                          ($urandom_range(0, 1) ? ALL_ONES : $urandom | 32'd1), '0, '0, '0);
            sent++;
        end
        words = $urandom_range(0, 6);
        off   = 12'($urandom_range(0, (sb.page_len > 4095) ? 4095 : sb.page_len + 2));
        for (int k = 0; k < words; k++) begin
            send_item(KIND_INIT_WORD, log_word(), off, 3'($urandom), 16'($urandom));
            sent++;
            off = (off == 0) ? 12'd0 : 12'($urandom_range(0, off - 1));
        end
        if (broken != 1) begin
            send_item(KIND_INIT_END, $urandom, 12'($urandom), 3'($urandom), 16'($urandom));
            sent++;
        end
    endtask

    task automatic random_phase(int count, bit with_hold);
        int sent;
        int r;
        bit held;
        sent = 0;
        held = 1'b0;
        while (sent < count) begin
            if (with_hold && !held && sent >= 10) begin
                hold_request = 1'b1;
                held         = 1'b1;
            end
            calm = (sent >= count / 2 && sent < count / 2 + 15);
            r = $urandom_range(0, 99);
            if (r < 35) init_sequence(sent);
            else begin
                if (r < 60)
                    send_item(KIND_UPDATE, $urandom, 12'($urandom), 3'($urandom_range(0, 7)),
                              ($urandom_range(0, 1) ? 16'($urandom_range(0, 2600))
                                                    : 16'($urandom)));
                else if (r < 75)
                    send_item(KIND_FLUSH, $urandom, 12'($urandom), 3'($urandom), 16'($urandom));
                else if (r < 90)
                    send_item(KIND_READ, $urandom, 12'($urandom), 3'($urandom), 16'($urandom));
                else
                    send_item(3'($urandom), $urandom, 12'($urandom), 3'($urandom),
                              16'($urandom));
                sent++;
            end
        end
        calm = 1'b0;
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: reads of every index, stray init items, unused kinds
        for (int i = 0; i < 8; i++) send_item(KIND_READ, '0, '0, 3'(i), '0);
        send_item(KIND_INIT_WORD, 32'h0005_0001, 12'd4095, '0, '0);
        send_item(KIND_INIT_END, '0, '0, '0, '0);
        send_item(3'd6, ALL_ONES, 12'hFFF, 3'd7, 16'sh7FFF);
        send_item(3'd7, '0, '0, '0, -16'sd32768);
        // scan with an erased top word, a found top and an out-of-range entry
        send_item(KIND_INIT_BEGIN, 32'hABCD_0000, '0, '0, '0);
        send_item(KIND_INIT_WORD, ALL_ONES, 12'd4095, '0, '0);
        send_item(KIND_INIT_WORD, 32'h0064_0002, 12'd2000, '0, '0);
        send_item(KIND_INIT_WORD, 32'h0BB8_0001, 12'd10, '0, '0);
        send_item(KIND_INIT_WORD, 32'h03E8_0000, 12'd0, '0, '0);
        send_item(KIND_INIT_END, '0, '0, '0, '0);
        // updates at the value extremes, an ignored index, a flush
        send_item(KIND_UPDATE, '0, '0, 3'd0, 16'sh7FFF);
        send_item(KIND_UPDATE, '0, '0, 3'd6, -16'sd32768);
        send_item(KIND_UPDATE, '0, '0, 3'd7, 16'sd5);
        send_item(KIND_FLUSH, '0, '0, '0, '0);
        // blank check with a dirty base word: erase then defaults
        send_item(KIND_INIT_BEGIN, 32'h1234_5678, '0, '0, '0);
        send_item(KIND_INIT_WORD, ALL_ONES, 12'd5, '0, '0);
        send_item(KIND_INIT_END, '0, '0, '0, '0);
        // scan with nothing found
        send_item(KIND_INIT_BEGIN, 32'h0000_0000, '0, '0, '0);
        send_item(KIND_INIT_END, '0, '0, '0, '0);

        random_phase(40, 1'b1);
        setup(32'hFFFF_FFFF, 3'd7, 13'd1, 13'd1);       // tiny page: refusals and erases
        random_phase(40, 1'b0);
        setup(32'h0000_0000, 3'd0, 13'd12, 13'd6);
        random_phase(40, 1'b0);
        setup($urandom, 3'($urandom), 13'd4096, 13'd4096);
        random_phase(35, 1'b0);
        setup($urandom, 3'($urandom), 13'($urandom_range(1, 40)), 13'($urandom_range(1, 40)));
        random_phase(35, 1'b0);

        while (sb.due_ops.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
        if (sb.mismatches == 0 && sb.due_ops.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
